[rtl/wqo_pkg.sv]
// ----------------------------------------------------------------------------
// wqo_pkg
// Shared types, constants and arithmetic helpers of the wavetable quadrature
// oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package wqo_pkg;

	// table geometry and phase format
	localparam int TABLE_SIZE  = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int PHASE_W     = 26;
	localparam int BANK_DEPTH  = TABLE_SIZE / 2;
	localparam int BANK_W      = $clog2(BANK_DEPTH);

	// sample arithmetic widths
	localparam int SAMPLE_W    = 18;
	localparam int DIFF_W      = SAMPLE_W + 1;
	localparam int PROD_W      = FRAC_BITS + 1 + DIFF_W;
	localparam int SHIFT_W     = PROD_W - FRAC_BITS;
	localparam int SUM_W       = SHIFT_W + 1;
	localparam int FIN_W       = SUM_W + 2;

	// stream and configuration port widths
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 40;
	localparam int REQ_W       = 2;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 26;

	// output queue
	localparam int OUT_DEPTH   = 2;
	localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_BITS;
	localparam logic signed [FIN_W-1:0] OUT_MAX  = FIN_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [FIN_W-1:0] OUT_MIN  = -FIN_W'(1 << (SAMPLE_W - 1));
	localparam logic signed [FIN_W-1:0] UNI_HALF = FIN_W'(1 << (FRAC_BITS - 1));

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_INCREMENT   = 2'd0,
		CFG_QUAD_OFFSET = 2'd1,
		CFG_INVERT      = 2'd2,
		CFG_UNIPOLAR    = 2'd3
	} cfg_reg_t;

	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// add the increment, fold back once past the table end
	function automatic phase_t wqo_advance(input phase_t phase, input phase_t inc);
		logic [PHASE_W:0] sum;
		sum = {1'b0, phase} + {1'b0, inc};
		if (sum >= PHASE_LIMIT) begin
			sum = sum - PHASE_LIMIT;
		end
		return sum[PHASE_W-1:0];
	endfunction

	// optional negation, optional unipolar map, saturation to the sample range
	function automatic sample_t wqo_finish(input logic signed [SUM_W-1:0] y,
		input logic inv, input logic uni);
		logic signed [FIN_W-1:0] v;
		v = {{(FIN_W - SUM_W){y[SUM_W-1]}}, y};
		if (inv) begin
			v = -v;
		end
		if (uni) begin
			v = (v >>> 1) + UNI_HALF;
		end
		if (v > OUT_MAX) begin
			v = OUT_MAX;
		end else if (v < OUT_MIN) begin
			v = OUT_MIN;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/wqo_ram.sv]
// ----------------------------------------------------------------------------
// wqo_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wqo_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/wavetable_quadrature_oscillator_core.sv]
// ----------------------------------------------------------------------------
// wavetable_quadrature_oscillator_core
// Two-phase wavetable oscillator with linear interpolation.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries requests: s_tuser is the kind (tick, table write, restart),
//   s_tdata the table index and value of a write. m_* carries one result per
//   tick: main and quadrature samples. cfg_* writes the four registers; the
//   user writes them only while the block is idle; the block does not enforce it.
//   The table sits in two RAM banks, even and odd entries, so one read fetches
//   an adjacent pair. A tick addresses the main pair in its acceptance cycle
//   and the quad pair in the cycle after, when the quad read holds s_tready
//   low, so no request of any kind is taken then; writes and restarts are
//   otherwise taken back to back.
//   A tick passes tick_s1, tick_s2 and tick_s3 before its result is queued.
//   One multiplier is shared between the two interpolations.
//   A two-entry output queue parts the sides; with two ticks outstanding
//   and m_tready low the input stalls.
//   Reset clears the phases, registers and queue; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_quadrature_oscillator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [wqo_pkg::IN_DATA_W-1:0]       s_tdata,  // table_index, table_value
	input  wire logic [wqo_pkg::REQ_W-1:0]           s_tuser,  // req_type
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [wqo_pkg::OUT_DATA_W-1:0]      m_tdata,  // sample, quad_sample
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [wqo_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [wqo_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	import wqo_pkg::*;

	localparam int PAIR_W = 2 * SAMPLE_W;

	// configuration registers
	phase_t inc_q;
	phase_t quad_offset_q;
	logic   invert_q;
	logic   unipolar_q;

	// oscillator state and pipeline
	phase_t                    main_phase_q;
	phase_t                    quad_phase_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic                      rd_lsb_q;
	logic                      tick_s1, tick_s2, tick_s3;
	logic signed [PROD_W-1:0]  prod_q;
	sample_t                   y0_q;
	sample_t                   sample_s3;

	// output queue and tick credit
	logic [PAIR_W-1:0]         out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0]      fill_q;
	logic [OUT_CNT_W-1:0]      credit_q;

	logic                      accept, tick_acc, pop;
	req_t                      req;
	logic [IDX_W-1:0]          wr_idx;
	sample_t                   wr_val;
	phase_t                    rd_phase;
	logic [IDX_W-1:0]          rd_idx;
	logic [BANK_W-1:0]         even_raddr, odd_raddr;
	sample_t                   even_rdata, odd_rdata;
	sample_t                   y0, y1;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   interp_sum;
	sample_t                   fin;

	// request decode
	assign req      = req_t'(s_tuser);
	assign s_tready = !tick_s1 && ((credit_q < OUT_CNT_W'(OUT_DEPTH)) || pop);
	assign accept   = s_tvalid && s_tready;
	assign tick_acc = accept && (req == REQ_TICK);
	assign wr_idx   = s_tdata[IDX_W-1:0];
	assign wr_val   = s_tdata[IDX_W +: SAMPLE_W];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q         <= '0;
			quad_offset_q <= '0;
			invert_q      <= 1'b0;
			unipolar_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				CFG_INCREMENT:   inc_q         <= cfg_wdata[PHASE_W-1:0];
				CFG_QUAD_OFFSET: quad_offset_q <= cfg_wdata[PHASE_W-1:0];
				CFG_INVERT:      invert_q      <= cfg_wdata[0];
				CFG_UNIPOLAR:    unipolar_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// read address: main pair on acceptance, quad pair in the following cycle
	assign rd_phase   = tick_s1 ? quad_phase_q : main_phase_q;
	assign rd_idx     = rd_phase[FRAC_BITS +: IDX_W];
	assign odd_raddr  = rd_idx[IDX_W-1:1];
	assign even_raddr = rd_idx[IDX_W-1:1] + BANK_W'(rd_idx[0]);

	// even and odd table banks; a write lands before any later tick reads it
	wqo_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_even_bank (
		.clk   (clk),
		.we    (accept && (req == REQ_WRITE) && !wr_idx[0]),
		.waddr (wr_idx[IDX_W-1:1]),
		.wdata (wr_val),
		.raddr (even_raddr),
		.rdata (even_rdata)
	);

	wqo_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
		.clk   (clk),
		.we    (accept && (req == REQ_WRITE) && wr_idx[0]),
		.waddr (wr_idx[IDX_W-1:1]),
		.wdata (wr_val),
		.raddr (odd_raddr),
		.rdata (odd_rdata)
	);

	// pair selection by the low index bit of the read just issued
	assign y0   = rd_lsb_q ? odd_rdata  : even_rdata;
	assign y1   = rd_lsb_q ? even_rdata : odd_rdata;
	assign diff = {y1[SAMPLE_W-1], y1} - {y0[SAMPLE_W-1], y0};
	assign prod = $signed({1'b0, frac_q}) * diff;

	// interpolation sum and output shaping from the registered product
	assign interp_sum = {{(SUM_W - SAMPLE_W){y0_q[SAMPLE_W-1]}}, y0_q}
		+ {prod_q[PROD_W-1], prod_q[PROD_W-1:FRAC_BITS]};
	assign fin = wqo_finish(interp_sum, invert_q, unipolar_q);

	// phases and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_phase_q <= '0;
			quad_phase_q <= '0;
			tick_s1      <= 1'b0;
			tick_s2      <= 1'b0;
			tick_s3      <= 1'b0;
		end else begin
			tick_s1 <= tick_acc;
			tick_s2 <= tick_s1;
			tick_s3 <= tick_s2;
			if (tick_acc) begin
				main_phase_q <= wqo_advance(main_phase_q, inc_q);
			end else if (accept && (req == REQ_RESTART)) begin
				main_phase_q <= '0;
				quad_phase_q <= quad_offset_q;
			end
			if (tick_s1) begin
				quad_phase_q <= wqo_advance(quad_phase_q, inc_q);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_lsb_q <= rd_idx[0];
		if (tick_acc) begin
			frac_q <= main_phase_q[FRAC_BITS-1:0];
		end
		if (tick_s1 || tick_s2) begin
			prod_q <= prod;
			y0_q   <= y0;
		end
		if (tick_s2) begin
			sample_s3 <= fin;
		end
		if (tick_s3) begin
			out_q[wr_ptr_q] <= {fin, sample_s3};
		end
	end

	// output queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (fill_q != '0);
	assign m_tdata  = {{(OUT_DATA_W - PAIR_W){1'b0}}, out_q[rd_ptr_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (tick_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({tick_s3, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: ;
			endcase
			case ({tick_acc, pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: ;
			endcase
		end
	end

	// checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("tick credit above queue depth");

	a_fill_le_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= credit_q)
		else $error("queue holds more results than outstanding ticks");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tick_s3 |-> (fill_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	a_quad_slot: assert property (@(posedge clk) disable iff (!arst_n)
		tick_s1 |-> !s_tready ##1 tick_s2)
		else $error("quad read cycle not held");

endmodule

`default_nettype wire
